// ===== hw/rtl/gyro_offset_calibrate_correct_macros.svh =====
// Assertion macros shared by the gyro offset calibration RTL.
`ifndef GYRO_OFFSET_CALIBRATE_CORRECT_MACROS_SVH
`define GYRO_OFFSET_CALIBRATE_CORRECT_MACROS_SVH

// Check a property outside reset.
`define GOC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define GOC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/goc_pkg.sv =====
package goc_pkg;

	// Fixed field widths of the result and the config index
	localparam int RATE_W    = 11;
	localparam int PROG_W    = 6;
	localparam int CFG_IDX_W = 3;
	// Width that holds any offset difference and its negation
	localparam int SAT_W     = 17;
	localparam logic signed [SAT_W-1:0] RATE_LIMIT = 17'sd1023;

	// Request type codes
	localparam logic REQ_CAL  = 1'b0;
	localparam logic REQ_MEAS = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROLL_REV   = 3'd0,
		REG_PITCH_REV  = 3'd1,
		REG_YAW_REV    = 3'd2,
		REG_VERTICAL   = 3'd3,
		REG_BOARD_POL  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic roll_rev;
		logic pitch_rev;
		logic yaw_rev;
		logic vertical;
		logic board_pol;
	} cfg_t;

	// Calibration control from the sequencer to every lane
	typedef struct packed {
		logic cal;    // calibration item transferred this cycle
		logic start;  // item opens a new run
		logic done;   // item completes the run
	} cal_ctl_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] roll_rate;
		logic signed [RATE_W-1:0] pitch_rate;
		logic signed [RATE_W-1:0] yaw_rate;
		logic                     calibrated;
		logic [PROG_W-1:0]        cal_progress;
	} result_t;

	// Negate on request and clamp to the rate range
	function automatic logic signed [RATE_W-1:0] sign_sat(
		input logic signed [SAT_W-1:0] d,
		input logic                    negate
	);
		logic signed [SAT_W-1:0] r;
		r = negate ? -d : d;
		if (r > RATE_LIMIT) begin
			r = RATE_LIMIT;
		end else if (r < -RATE_LIMIT) begin
			r = -RATE_LIMIT;
		end
		return r[RATE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/goc_ctrl.sv =====
module goc_ctrl import goc_pkg::*; #(
	parameter int CAL_SAMPLES_LOG2 = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      req_type,
	output cal_ctl_t                  ctl,
	output logic                      calibrated_nxt,
	output logic [PROG_W-1:0]         progress_nxt,
	output logic [CAL_SAMPLES_LOG2:0] cal_count,
	output logic                      calibrated
);

	localparam int CNT_W = CAL_SAMPLES_LOG2 + 1;
	localparam logic [CNT_W-1:0] CAL_TOTAL = CNT_W'(1) << CAL_SAMPLES_LOG2;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_nxt;
	logic             flag_q;
	logic             is_cal;
	logic             start;
	logic             done;
	logic [31:0]      cnt_ext;

	// Decide run start and completion for a calibration transfer
	always_comb begin
		is_cal  = accept && (req_type == REQ_CAL);
		start   = (cnt_q == '0) || (cnt_q == CAL_TOTAL);
		cnt_inc = (start ? '0 : cnt_q) + CNT_W'(1);
		done    = (cnt_inc == CAL_TOTAL);
		cnt_nxt = is_cal ? cnt_inc : cnt_q;
		if (is_cal) begin
			calibrated_nxt = done ? 1'b1 : (start ? 1'b0 : flag_q);
		end else begin
			calibrated_nxt = flag_q;
		end
		ctl = '{cal: is_cal, start: start, done: done};
	end

	// Report the count after this item, cut to the progress field
	assign cnt_ext      = 32'(cnt_nxt);
	assign progress_nxt = cnt_ext[PROG_W-1:0];

	// Advance run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			flag_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_nxt;
			flag_q <= calibrated_nxt;
		end
	end

	assign cal_count  = cnt_q;
	assign calibrated = flag_q;

endmodule

// ===== hw/rtl/goc_lane.sv =====
module goc_lane import goc_pkg::*; #(
	parameter int CAL_SAMPLES_LOG2 = 5,
	parameter int ADC_BITS         = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cal_ctl_t                   ctl,
	input  logic [ADC_BITS-1:0]        sample,
	output logic signed [ADC_BITS:0]   diff
);

	localparam int SUM_W = ADC_BITS + CAL_SAMPLES_LOG2;

	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_nxt;
	logic [ADC_BITS-1:0] offset_q;

	// Restart or extend the channel sum
	assign sum_nxt = (ctl.start ? '0 : sum_q) + SUM_W'(sample);

	// Hold sum and offset; clear offset on run start, load mean on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			offset_q <= '0;
		end else if (ctl.cal) begin
			sum_q <= sum_nxt;
			if (ctl.done) begin
				offset_q <= sum_nxt[SUM_W-1:CAL_SAMPLES_LOG2];
			end else if (ctl.start) begin
				offset_q <= '0;
			end
		end
	end

	// Remove the zero offset
	assign diff = $signed({1'b0, sample}) - $signed({1'b0, offset_q});

endmodule

// ===== hw/rtl/goc_merge.sv =====
module goc_merge import goc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                     req_type,
	input  cfg_t                     cfg,
	input  logic signed [ADC_BITS:0] roll_diff,
	input  logic signed [ADC_BITS:0] pitch_diff,
	input  logic signed [ADC_BITS:0] yaw_diff,
	input  logic                     calibrated,
	input  logic [PROG_W-1:0]        cal_progress,
	output result_t                  res
);

	logic signed [SAT_W-1:0] roll_ext;
	logic signed [SAT_W-1:0] pitch_ext;
	logic signed [SAT_W-1:0] yaw_ext;
	logic                    neg_roll;
	logic                    neg_pitch;

	assign roll_ext  = SAT_W'(roll_diff);
	assign pitch_ext = SAT_W'(pitch_diff);
	assign yaw_ext   = SAT_W'(yaw_diff);

	// Board polarity flips roll and pitch; vertical mount flips pitch back
	assign neg_roll  = (cfg.roll_rev == cfg.board_pol);
	assign neg_pitch = cfg.vertical ? (cfg.pitch_rev != cfg.board_pol)
	                                : (cfg.pitch_rev == cfg.board_pol);

	// Route lanes to axes and apply signs; calibration items give zero rates
	always_comb begin
		res.calibrated   = calibrated;
		res.cal_progress = cal_progress;
		if (req_type == REQ_CAL) begin
			res.roll_rate  = '0;
			res.pitch_rate = '0;
			res.yaw_rate   = '0;
		end else begin
			res.roll_rate = sign_sat(roll_ext, neg_roll);
			if (cfg.vertical) begin
				res.pitch_rate = sign_sat(yaw_ext, neg_pitch);
				res.yaw_rate   = sign_sat(pitch_ext, cfg.yaw_rev);
			end else begin
				res.pitch_rate = sign_sat(pitch_ext, neg_pitch);
				res.yaw_rate   = sign_sat(yaw_ext, cfg.yaw_rev);
			end
		end
	end

endmodule

// ===== hw/rtl/goc_obuf.sv =====
module goc_obuf import goc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// Store results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// Track fill level and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/gyro_offset_calibrate_correct.sv =====
// Three-axis gyro zero-offset calibration and rate correction. Each transfer
// carries one raw ADC sample for roll, pitch and yaw. Calibration items
// (req_type 0) are summed per axis; the first of a run clears sums, offsets
// and the calibrated flag, and after 2^CAL_SAMPLES_LOG2 items each offset
// becomes the mean and calibrated is set. Their result has zero rates.
// Measurement items (req_type 1) return sample minus offset, signed by the
// reverse bits and board polarity, with pitch and yaw sources swapped in
// vertical mode, clamped to +/-1023. Rate: one item per cycle while the
// output buffer has room; the three axis lanes and the state update finish
// in the accept cycle, and each result is written to the output buffer. A
// two-entry output buffer keeps input transfers flowing while at most one
// result waits; input ready drops only when both entries are full.
// Configuration writes are always ready and take effect on the next item.
`include "gyro_offset_calibrate_correct_macros.svh"

module gyro_offset_calibrate_correct import goc_pkg::*; #(
	parameter int CAL_SAMPLES_LOG2 = 5,
	parameter int ADC_BITS         = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [ADC_BITS-1:0]      roll_sample,
	input  logic [ADC_BITS-1:0]      pitch_sample,
	input  logic [ADC_BITS-1:0]      yaw_sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [RATE_W-1:0] roll_rate,
	output logic signed [RATE_W-1:0] pitch_rate,
	output logic signed [RATE_W-1:0] yaw_rate,
	output logic                     calibrated,
	output logic [PROG_W-1:0]        cal_progress,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic                     cfg_data
);

	localparam int CNT_W = CAL_SAMPLES_LOG2 + 1;
	localparam logic [CNT_W-1:0] CAL_TOTAL = CNT_W'(1) << CAL_SAMPLES_LOG2;

	cfg_t                    cfg_q;
	cal_ctl_t                ctl;
	logic                    accept;
	logic                    calibrated_nxt;
	logic [PROG_W-1:0]       progress_nxt;
	logic [CNT_W-1:0]        cal_count_q;
	logic                    calibrated_q;
	logic signed [ADC_BITS:0] roll_diff;
	logic signed [ADC_BITS:0] pitch_diff;
	logic signed [ADC_BITS:0] yaw_diff;
	result_t                 res;
	result_t                 out_res;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROLL_REV:  cfg_q.roll_rev  <= cfg_data;
				REG_PITCH_REV: cfg_q.pitch_rev <= cfg_data;
				REG_YAW_REV:   cfg_q.yaw_rev   <= cfg_data;
				REG_VERTICAL:  cfg_q.vertical  <= cfg_data;
				REG_BOARD_POL: cfg_q.board_pol <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	// Run sequencer
	goc_ctrl #(
		.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req_type),
		.ctl           (ctl),
		.calibrated_nxt(calibrated_nxt),
		.progress_nxt  (progress_nxt),
		.cal_count     (cal_count_q),
		.calibrated    (calibrated_q)
	);

	// One lane per gyro channel
	goc_lane #(
		.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2),
		.ADC_BITS        (ADC_BITS)
	) u_lane_roll (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sample(roll_sample),
		.diff  (roll_diff)
	);

	goc_lane #(
		.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2),
		.ADC_BITS        (ADC_BITS)
	) u_lane_pitch (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sample(pitch_sample),
		.diff  (pitch_diff)
	);

	goc_lane #(
		.CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2),
		.ADC_BITS        (ADC_BITS)
	) u_lane_yaw (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sample(yaw_sample),
		.diff  (yaw_diff)
	);

	// Combine lanes into axis rates
	goc_merge #(
		.ADC_BITS(ADC_BITS)
	) u_merge (
		.req_type    (req_type),
		.cfg         (cfg_q),
		.roll_diff   (roll_diff),
		.pitch_diff  (pitch_diff),
		.yaw_diff    (yaw_diff),
		.calibrated  (calibrated_nxt),
		.cal_progress(progress_nxt),
		.res         (res)
	);

	// Result buffer
	goc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign roll_rate    = out_res.roll_rate;
	assign pitch_rate   = out_res.pitch_rate;
	assign yaw_rate     = out_res.yaw_rate;
	assign calibrated   = out_res.calibrated;
	assign cal_progress = out_res.cal_progress;

	`GOC_ASSERT(a_flag_needs_full_run, clk, arst_n, calibrated_q |-> (cal_count_q == CAL_TOTAL), "calibrated without a full run")
	`GOC_ASSERT(a_count_in_range, clk, arst_n, cal_count_q <= CAL_TOTAL, "calibration count past run length")
	`GOC_ASSERT(a_meas_keeps_run, clk, arst_n, (accept && (req_type == REQ_MEAS)) |=> ($stable(cal_count_q) && $stable(calibrated_q)), "measurement disturbed the run")
	`GOC_ASSERT_ALWAYS(a_reset_clears, clk, !arst_n |-> (!out_valid && (cal_count_q == '0) && !calibrated_q), "state not cleared in reset")

endmodule
